### rtl/sha1_pkg.sv
// Shared types and constants of the SHA-1 hasher.
`default_nettype none

package sha1_pkg;

    localparam int ROUNDS       = 80;
    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_BYTES  = 64;

    // Fill level at which the length field starts
    localparam logic [5:0] LEN_FILL  = 6'd56;
    localparam logic [5:0] LAST_FILL = 6'd63;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV_WORDS [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K_00_19 = 32'h5a827999;
    localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
    localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
    localparam logic [31:0] K_60_79 = 32'hca62c1d6;

    // Source of the byte shifted into the block
    typedef enum logic [1:0] {
        SEL_MSG  = 2'd0,
        SEL_PAD  = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      shift;      // shift one byte into the block
        byte_sel_t byte_sel;
        logic      load_vars;  // load a..e from the chaining value
        logic      round;      // run one compression round
        logic      fold;       // add a..e into the chaining value
        logic      out_adv;    // advance to the next digest word
        logic      clear;      // restore IV and zero the length
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
        logic       out_last;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/sha1_dp.sv
// Datapath of the SHA-1 hasher: block shifter, round logic, chaining value.
`default_nettype none

module sha1_dp
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  in_byte,
    input  wire dp_cmd_t     cmd,
    output dp_sts_t          sts,
    output logic [31:0]      digest_word
);

    logic [31:0] w_reg     [16];
    logic [31:0] w_next    [16];
    logic [31:0] var_reg   [5];
    logic [31:0] var_next  [5];
    logic [31:0] chain_reg [DIGEST_WORDS];
    logic [31:0] chain_next[DIGEST_WORDS];
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;

    logic [7:0]  byte_in;
    logic [63:0] len_shift;
    logic [31:0] w_new;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] tmp;
    logic        round_last;
    logic        out_last;

    // Pick the byte to shift in
    assign len_shift = len_reg >> {3'd7 - fill_reg[2:0], 3'b000};

    always_comb
    begin
        case (cmd.byte_sel)
            SEL_MSG:  byte_in = in_byte;
            SEL_PAD:  byte_in = PAD_BYTE;
            SEL_LEN:  byte_in = len_shift[7:0];
            default:  byte_in = 8'h00;
        endcase
    end

    // Round function and constant by round range
    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f_val = (var_reg[1] & var_reg[2]) | (~var_reg[1] & var_reg[3]);
            k_val = K_00_19;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K_20_39;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (var_reg[1] & var_reg[2]) ^ (var_reg[1] & var_reg[3])
                  ^ (var_reg[2] & var_reg[3]);
            k_val = K_40_59;
        end
        else
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K_60_79;
        end
    end

    assign tmp = {var_reg[0][26:0], var_reg[0][31:27]} + f_val + var_reg[4] + k_val
               + w_reg[0];

    // Rolling schedule: the word sixteen rounds ahead
    logic [31:0] w_mix;
    assign w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    assign round_last = (rnd_reg == 7'(ROUNDS - 1));
    assign out_last   = (idx_reg == 3'(DIGEST_WORDS - 1));

    // Block shifter: bytes enter at the bottom, rounds consume the top word
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (cmd.shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = {w_reg[i][23:0], w_reg[i + 1][31:24]};
            end
            w_next[15] = {w_reg[15][23:0], byte_in};
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = w_new;
        end
    end

    // Working variables a..e
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            var_next[i] = var_reg[i];
        end
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 5; i++)
            begin
                var_next[i] = chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            var_next[0] = tmp;
            var_next[1] = var_reg[0];
            var_next[2] = {var_reg[1][1:0], var_reg[1][31:2]};
            var_next[3] = var_reg[2];
            var_next[4] = var_reg[3];
        end
    end

    // Chaining value, counters and length
    always_comb
    begin
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            chain_next[i] = chain_reg[i];
            if (cmd.clear)
            begin
                chain_next[i] = IV_WORDS[i];
            end
            else if (cmd.fold)
            begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
        end

        fill_next = cmd.shift ? fill_reg + 6'd1 : fill_reg;

        len_next = len_reg;
        if (cmd.clear)
        begin
            len_next = '0;
        end
        else if (cmd.shift && (cmd.byte_sel == SEL_MSG))
        begin
            len_next = len_reg + 64'd8;
        end

        rnd_next = rnd_reg;
        if (cmd.load_vars)
        begin
            rnd_next = '0;
        end
        else if (cmd.round)
        begin
            rnd_next = rnd_reg + 7'd1;
        end

        idx_next = idx_reg;
        if (cmd.out_adv)
        begin
            idx_next = out_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        for (int i = 0; i < 5; i++)
        begin
            var_reg[i] <= var_next[i];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= IV_WORDS[i];
            end
            fill_reg <= '0;
            len_reg  <= '0;
            rnd_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
            fill_reg <= fill_next;
            len_reg  <= len_next;
            rnd_reg  <= rnd_next;
            idx_reg  <= idx_next;
        end
    end

    assign digest_word    = chain_reg[idx_reg];
    assign sts.fill       = fill_reg;
    assign sts.round_last = round_last;
    assign sts.out_last   = out_last;

    // A clear always restores the first IV word and zeroes the length
    a_clear_iv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (chain_reg[0] == IV_WORDS[0]) && (len_reg == 64'd0))
        else $error("chaining value not restored after digest");

endmodule

`default_nettype wire

### rtl/sha1_ctrl.sv
// Controller of the SHA-1 hasher: input, padding, rounds and digest output.
`default_nettype none

module sha1_ctrl
    import sha1_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    in_has_byte,
    input  wire logic    in_end,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   end_reg, end_next;   // message end seen, padding still owed
    logic   pad_reg, pad_next;   // 0x80 already placed
    logic   len_reg, len_next;   // length bytes under way

    logic   block_full;

    assign block_full = (sts.fill == LAST_FILL);

    always_comb
    begin
        state_next = state_reg;
        end_next   = end_reg;
        pad_next   = pad_reg;
        len_next   = len_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        case (state_reg)
            // Take one beat, shift in its byte if it carries one
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    end_next = in_end;
                    if (in_has_byte)
                    begin
                        cmd.shift    = 1'b1;
                        cmd.byte_sel = SEL_MSG;
                        if (block_full)
                        begin
                            cmd.load_vars = 1'b1;
                            state_next    = ST_ROUND;
                        end
                        else if (in_end)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (in_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            // Append 0x80, zeros, then the bit length, one byte a cycle between compressions
            ST_PAD:
            begin
                cmd.shift = 1'b1;
                if (!pad_reg)
                begin
                    cmd.byte_sel = SEL_PAD;
                    pad_next     = 1'b1;
                end
                else if (len_reg || (sts.fill == LEN_FILL))
                begin
                    cmd.byte_sel = SEL_LEN;
                    len_next     = 1'b1;
                end
                else
                begin
                    cmd.byte_sel = SEL_ZERO;
                end
                if (block_full)
                begin
                    cmd.load_vars = 1'b1;
                    state_next    = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (sts.round_last)
                begin
                    state_next = ST_FOLD;
                end
            end

            // Add the working variables into the chaining value
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (len_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (end_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // Drive the five digest words, then restart
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.out_adv = 1'b1;
                    if (sts.out_last)
                    begin
                        cmd.clear  = 1'b1;
                        end_next   = 1'b0;
                        pad_next   = 1'b0;
                        len_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            end_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            len_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            end_reg   <= end_next;
            pad_reg   <= pad_next;
            len_reg   <= len_next;
        end
    end

    // The digest only goes out on a block boundary
    a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (sts.fill == 6'd0))
        else $error("digest output with a partial block pending");

    // A full block always starts the rounds
    a_block_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_vars |=> (state_reg == ST_ROUND))
        else $error("block loaded without compression");

    // Length bytes come only after the pad byte
    a_len_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && (cmd.byte_sel == SEL_LEN)) |-> pad_reg)
        else $error("length written before the pad byte");

endmodule

`default_nettype wire

### rtl/sha1_message_hasher_top.sv
// Top level of the SHA-1 hasher: stream ports around controller and datapath.
//
//  channel   dir  tdata                     tuser           tlast
//  s_axis    in   [7:0] msg_byte            byte_valid      end_of_message
//  m_axis    out  [31:0] digest_word        -               digest_last
//
// Message bytes are taken one per cycle while tready is high; every 64th
// byte starts the 80 single-cycle compression rounds and the chaining-value add.
// The end beat is followed by the padding bytes (9 to 72) and one or two
// compressions, then five output beats; tready is low throughout.
// Reset loads the SHA-1 initial values and clears fill and length.
// A stalled m_axis holds the current digest word until taken.
`default_nettype none

module sha1_message_hasher_top
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  wire logic        s_axis_tuser,   // [0] byte_valid
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic             m_axis_tlast
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    sha1_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_has_byte (s_axis_tuser),
        .in_end      (s_axis_tlast),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .sts         (sts),
        .cmd         (cmd)
    );

    sha1_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (s_axis_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (m_axis_tdata)
    );

    assign m_axis_tlast = sts.out_last;

endmodule

`default_nettype wire
